// ===== rtl/lts_pkg.sv =====
// Shared types, constants and helper functions of the Lox token scanner.
package lts_pkg;

  localparam int POS_W       = 24;
  localparam int LINE_W      = 16;
  localparam int KIND_W      = 6;
  localparam int ERR_W       = 2;
  localparam int IDLEN_W     = 3;
  localparam int KWBUF_DEPTH = 6;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_CW     = 4;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam logic [KIND_W-1:0] K_LPAREN    = 6'd0;
  localparam logic [KIND_W-1:0] K_RPAREN    = 6'd1;
  localparam logic [KIND_W-1:0] K_LBRACE    = 6'd2;
  localparam logic [KIND_W-1:0] K_RBRACE    = 6'd3;
  localparam logic [KIND_W-1:0] K_COMMA     = 6'd4;
  localparam logic [KIND_W-1:0] K_DOT       = 6'd5;
  localparam logic [KIND_W-1:0] K_MINUS     = 6'd6;
  localparam logic [KIND_W-1:0] K_PLUS      = 6'd7;
  localparam logic [KIND_W-1:0] K_SEMI      = 6'd8;
  localparam logic [KIND_W-1:0] K_SLASH     = 6'd9;
  localparam logic [KIND_W-1:0] K_STAR      = 6'd10;
  localparam logic [KIND_W-1:0] K_BANG      = 6'd11;
  localparam logic [KIND_W-1:0] K_BANG_EQ   = 6'd12;
  localparam logic [KIND_W-1:0] K_EQUAL     = 6'd13;
  localparam logic [KIND_W-1:0] K_EQUAL_EQ  = 6'd14;
  localparam logic [KIND_W-1:0] K_GREATER   = 6'd15;
  localparam logic [KIND_W-1:0] K_GREATER_EQ = 6'd16;
  localparam logic [KIND_W-1:0] K_LESS      = 6'd17;
  localparam logic [KIND_W-1:0] K_LESS_EQ   = 6'd18;
  localparam logic [KIND_W-1:0] K_IDENT     = 6'd19;
  localparam logic [KIND_W-1:0] K_STRING    = 6'd20;
  localparam logic [KIND_W-1:0] K_NUMBER    = 6'd21;
  localparam logic [KIND_W-1:0] K_AND       = 6'd22;
  localparam logic [KIND_W-1:0] K_CLASS     = 6'd23;
  localparam logic [KIND_W-1:0] K_ELSE      = 6'd24;
  localparam logic [KIND_W-1:0] K_FALSE     = 6'd25;
  localparam logic [KIND_W-1:0] K_FOR       = 6'd26;
  localparam logic [KIND_W-1:0] K_FUN       = 6'd27;
  localparam logic [KIND_W-1:0] K_IF        = 6'd28;
  localparam logic [KIND_W-1:0] K_NIL       = 6'd29;
  localparam logic [KIND_W-1:0] K_OR        = 6'd30;
  localparam logic [KIND_W-1:0] K_PRINT     = 6'd31;
  localparam logic [KIND_W-1:0] K_RETURN    = 6'd32;
  localparam logic [KIND_W-1:0] K_SUPER     = 6'd33;
  localparam logic [KIND_W-1:0] K_THIS      = 6'd34;
  localparam logic [KIND_W-1:0] K_TRUE      = 6'd35;
  localparam logic [KIND_W-1:0] K_VAR       = 6'd36;
  localparam logic [KIND_W-1:0] K_WHILE     = 6'd37;
  localparam logic [KIND_W-1:0] K_ERROR     = 6'd38;
  localparam logic [KIND_W-1:0] K_EOF       = 6'd39;

  localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 2'd2;

  typedef enum logic [8:0] {
    M_IDLE     = 9'b000000001,
    M_IDENT    = 9'b000000010,
    M_NUMBER   = 9'b000000100,
    M_NUMDOT   = 9'b000001000,
    M_FRACTION = 9'b000010000,
    M_STRING   = 9'b000100000,
    M_OPER     = 9'b001000000,
    M_SLASH    = 9'b010000000,
    M_COMMENT  = 9'b100000000
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_BANG    = 3'd1,
    OP_EQUAL   = 3'd2,
    OP_LESS    = 3'd3,
    OP_GREATER = 3'd4
  } op_t;

  typedef logic [KWBUF_DEPTH-1:0][7:0] kwbuf_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic [1:0]     n;
    tok_t [2:0]     e;
  } tok_wr_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [KIND_W-1:0] op_single(input op_t op);
    logic [KIND_W-1:0] k;
    case (op)
      OP_BANG:    k = K_BANG;
      OP_EQUAL:   k = K_EQUAL;
      OP_LESS:    k = K_LESS;
      OP_GREATER: k = K_GREATER;
      default:    k = K_LPAREN;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] op_double(input op_t op);
    logic [KIND_W-1:0] k;
    case (op)
      OP_BANG:    k = K_BANG_EQ;
      OP_EQUAL:   k = K_EQUAL_EQ;
      OP_LESS:    k = K_LESS_EQ;
      OP_GREATER: k = K_GREATER_EQ;
      default:    k = K_LPAREN;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input kwbuf_t b, input logic [IDLEN_W-1:0] n);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if ({b[0], b[1]} == "if") k = K_IF;
        else if ({b[0], b[1]} == "or") k = K_OR;
      end
      3'd3: begin
        if ({b[0], b[1], b[2]} == "and") k = K_AND;
        else if ({b[0], b[1], b[2]} == "for") k = K_FOR;
        else if ({b[0], b[1], b[2]} == "fun") k = K_FUN;
        else if ({b[0], b[1], b[2]} == "nil") k = K_NIL;
        else if ({b[0], b[1], b[2]} == "var") k = K_VAR;
      end
      3'd4: begin
        if ({b[0], b[1], b[2], b[3]} == "else") k = K_ELSE;
        else if ({b[0], b[1], b[2], b[3]} == "this") k = K_THIS;
        else if ({b[0], b[1], b[2], b[3]} == "true") k = K_TRUE;
      end
      3'd5: begin
        if ({b[0], b[1], b[2], b[3], b[4]} == "class") k = K_CLASS;
        else if ({b[0], b[1], b[2], b[3], b[4]} == "false") k = K_FALSE;
        else if ({b[0], b[1], b[2], b[3], b[4]} == "print") k = K_PRINT;
        else if ({b[0], b[1], b[2], b[3], b[4]} == "super") k = K_SUPER;
        else if ({b[0], b[1], b[2], b[3], b[4]} == "while") k = K_WHILE;
      end
      3'd6: begin
        if ({b[0], b[1], b[2], b[3], b[4], b[5]} == "return") k = K_RETURN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/lts_core.sv =====
// Scanner state registers and the per-byte token logic.
module lts_core import lts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] text_byte,
  input  logic       end_of_input,
  output tok_wr_t    wr
);

  mode_t               mode_r, mode_nxt;
  op_t                 op_r, op_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    ls_r, ls_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  kwbuf_t              buf_r, buf_nxt;
  logic [IDLEN_W-1:0]  ilen_r, ilen_nxt;

  logic [POS_W-1:0]  one, len, len1, dot, line_unused;
  logic [LINE_W-1:0] line_inc;
  logic              a_v, b_v, c_v, go_idle;
  tok_t              a_t, b_t, c_t;
  logic [1:0]        n;

  function automatic tok_t mk(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
                              input logic [POS_W-1:0] start, input logic [POS_W-1:0] ln,
                              input logic [LINE_W-1:0] line);
    tok_t t;
    t.kind  = kind;
    t.err   = err;
    t.start = start;
    t.len   = ln;
    t.line  = line;
    t.last  = 1'b0;
    return t;
  endfunction

  assign line_unused = '0;

  always_comb begin
    mode_nxt = mode_r;
    op_nxt   = op_r;
    pos_nxt  = pos_r;
    ls_nxt   = ls_r;
    line_nxt = line_r;
    buf_nxt  = buf_r;
    ilen_nxt = ilen_r;
    one      = {{(POS_W-1){1'b0}}, (pos_r != POS_MAX)};
    len      = pos_r - ls_r;
    len1     = len + one;
    dot      = (pos_r > ls_r) ? pos_r - {{(POS_W-1){1'b0}}, 1'b1} : ls_r;
    line_inc = line_r + {{(LINE_W-1){1'b0}}, (line_r != LINE_MAX)};
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_t = mk(K_EOF, ERR_NONE, pos_r, line_unused, line_r);
    b_t = a_t;
    c_t = a_t;
    go_idle = 1'b0;

    if (end_of_input) begin
      case (mode_r)
        M_IDENT: begin
          a_v = 1'b1;
          a_t = mk(kw_kind(buf_r, ilen_r), ERR_NONE, ls_r, len, line_r);
        end
        M_NUMBER, M_FRACTION: begin
          a_v = 1'b1;
          a_t = mk(K_NUMBER, ERR_NONE, ls_r, len, line_r);
        end
        M_NUMDOT: begin
          a_v = 1'b1;
          b_v = 1'b1;
          a_t = mk(K_NUMBER, ERR_NONE, ls_r, dot - ls_r, line_r);
          b_t = mk(K_DOT, ERR_NONE, dot, {{(POS_W-1){1'b0}}, 1'b1}, line_r);
        end
        M_STRING: begin
          a_v = 1'b1;
          a_t = mk(K_ERROR, ERR_UNTERMINATED, ls_r, len, line_r);
        end
        M_OPER: begin
          a_v = 1'b1;
          a_t = mk(op_single(op_r), ERR_NONE, ls_r, len, line_r);
        end
        M_SLASH: begin
          a_v = 1'b1;
          a_t = mk(K_SLASH, ERR_NONE, ls_r, len, line_r);
        end
        default: a_v = 1'b0;
      endcase
      c_v = 1'b1;
      c_t = mk(K_EOF, ERR_NONE, pos_r, '0, line_r);
      mode_nxt = M_IDLE;
      op_nxt   = OP_NONE;
      pos_nxt  = '0;
      ls_nxt   = '0;
      line_nxt = {{(LINE_W-1){1'b0}}, 1'b1};
      buf_nxt  = '0;
      ilen_nxt = '0;
    end else begin
      pos_nxt = pos_r + one;
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(text_byte) || is_digit(text_byte)) begin
            for (int i = 0; i < KWBUF_DEPTH; i++) begin
              if (ilen_r == IDLEN_W'(i)) buf_nxt[i] = text_byte;
            end
            if (ilen_r != 3'd7) ilen_nxt = ilen_r + 3'd1;
          end else begin
            a_v = 1'b1;
            a_t = mk(kw_kind(buf_r, ilen_r), ERR_NONE, ls_r, len, line_r);
            go_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (text_byte == ".") begin
            mode_nxt = M_NUMDOT;
          end else if (!is_digit(text_byte)) begin
            a_v = 1'b1;
            a_t = mk(K_NUMBER, ERR_NONE, ls_r, len, line_r);
            go_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(text_byte)) begin
            mode_nxt = M_FRACTION;
          end else begin
            a_v = 1'b1;
            b_v = 1'b1;
            a_t = mk(K_NUMBER, ERR_NONE, ls_r, dot - ls_r, line_r);
            b_t = mk(K_DOT, ERR_NONE, dot, {{(POS_W-1){1'b0}}, 1'b1}, line_r);
            go_idle = 1'b1;
          end
        end
        M_FRACTION: begin
          if (!is_digit(text_byte)) begin
            a_v = 1'b1;
            a_t = mk(K_NUMBER, ERR_NONE, ls_r, len, line_r);
            go_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (text_byte == "\"") begin
            a_v = 1'b1;
            a_t = mk(K_STRING, ERR_NONE, ls_r, len1, line_r);
            mode_nxt = M_IDLE;
          end else if (text_byte == "\n") begin
            line_nxt = line_inc;
          end
        end
        M_OPER: begin
          a_v    = 1'b1;
          op_nxt = OP_NONE;
          if (text_byte == "=") begin
            a_t = mk(op_double(op_r), ERR_NONE, ls_r, len1, line_r);
            mode_nxt = M_IDLE;
          end else begin
            a_t = mk(op_single(op_r), ERR_NONE, ls_r, len, line_r);
            go_idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (text_byte == "/") begin
            mode_nxt = M_COMMENT;
          end else begin
            a_v = 1'b1;
            a_t = mk(K_SLASH, ERR_NONE, ls_r, len, line_r);
            go_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (text_byte == "\n") go_idle = 1'b1;
        end
        default: go_idle = 1'b1;
      endcase

      if (go_idle) begin
        mode_nxt = M_IDLE;
        ls_nxt   = pos_r;
        case (text_byte) inside
          " ", "\r", "\t": c_v = 1'b0;
          "\n": line_nxt = line_inc;
          "(": begin c_v = 1'b1; c_t = mk(K_LPAREN, ERR_NONE, pos_r, one, line_r); end
          ")": begin c_v = 1'b1; c_t = mk(K_RPAREN, ERR_NONE, pos_r, one, line_r); end
          "{": begin c_v = 1'b1; c_t = mk(K_LBRACE, ERR_NONE, pos_r, one, line_r); end
          "}": begin c_v = 1'b1; c_t = mk(K_RBRACE, ERR_NONE, pos_r, one, line_r); end
          ",": begin c_v = 1'b1; c_t = mk(K_COMMA, ERR_NONE, pos_r, one, line_r); end
          ".": begin c_v = 1'b1; c_t = mk(K_DOT, ERR_NONE, pos_r, one, line_r); end
          "-": begin c_v = 1'b1; c_t = mk(K_MINUS, ERR_NONE, pos_r, one, line_r); end
          "+": begin c_v = 1'b1; c_t = mk(K_PLUS, ERR_NONE, pos_r, one, line_r); end
          ";": begin c_v = 1'b1; c_t = mk(K_SEMI, ERR_NONE, pos_r, one, line_r); end
          "*": begin c_v = 1'b1; c_t = mk(K_STAR, ERR_NONE, pos_r, one, line_r); end
          "!": begin mode_nxt = M_OPER; op_nxt = OP_BANG; end
          "=": begin mode_nxt = M_OPER; op_nxt = OP_EQUAL; end
          "<": begin mode_nxt = M_OPER; op_nxt = OP_LESS; end
          ">": begin mode_nxt = M_OPER; op_nxt = OP_GREATER; end
          "/": mode_nxt = M_SLASH;
          "\"": mode_nxt = M_STRING;
          default: begin
            if (is_alpha(text_byte)) begin
              mode_nxt   = M_IDENT;
              buf_nxt    = '0;
              buf_nxt[0] = text_byte;
              ilen_nxt   = 3'd1;
            end else if (is_digit(text_byte)) begin
              mode_nxt = M_NUMBER;
            end else begin
              c_v = 1'b1;
              c_t = mk(K_ERROR, ERR_UNEXPECTED, pos_r, one, line_r);
            end
          end
        endcase
      end
    end

    n = 2'(a_v) + 2'(b_v) + 2'(c_v);
    wr.n         = take ? n : 2'd0;
    wr.e[0]      = a_v ? a_t : c_t;
    wr.e[1]      = b_v ? b_t : c_t;
    wr.e[2]      = c_t;
    wr.e[0].last = (n == 2'd1);
    wr.e[1].last = (n == 2'd2);
    wr.e[2].last = (n == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      op_r   <= OP_NONE;
      pos_r  <= '0;
      ls_r   <= '0;
      line_r <= {{(LINE_W-1){1'b0}}, 1'b1};
      buf_r  <= '0;
      ilen_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      op_r   <= op_nxt;
      pos_r  <= pos_nxt;
      ls_r   <= ls_nxt;
      line_r <= line_nxt;
      buf_r  <= buf_nxt;
      ilen_r <= ilen_nxt;
    end
  end

endmodule

// ===== rtl/lts_fifo.sv =====
// Result queue that takes up to three tokens a cycle and releases one.
module lts_fifo import lts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  tok_wr_t wr,
  input  logic    rd,
  output tok_t    head,
  output logic    not_empty,
  output logic    has_room
);

  tok_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_AW-1:0] tail_r, tail_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  assign head      = mem_r[head_r];
  assign not_empty = (count_r != '0);
  assign has_room  = (count_r <= FIFO_CW'(FIFO_DEPTH - 3));

  always_comb begin
    head_nxt  = head_r + FIFO_AW'(rd);
    tail_nxt  = tail_r + FIFO_AW'(wr.n);
    count_nxt = count_r + FIFO_CW'(wr.n) - FIFO_CW'(rd);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (wr.n > 2'(i)) mem_r[tail_r + FIFO_AW'(i)] <= wr.e[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/lox_token_scanner.sv =====
// Top level of the Lox token scanner: scanner core feeding a token queue.
//
//   Channel  Handshake             Word
//   in       in_valid / in_ready   one source byte or an end-of-input mark
//   out      out_valid / out_ready one token with kind, error, start, length, line
//
// One byte is taken in every cycle while the token queue has room for three tokens.
// A byte's tokens are written to the queue at the clock edge that accepts it and
// leave it behind earlier tokens, one token a cycle while out_ready is high.
// A stall on the output lets tokens collect in the eight-entry queue, and in_ready
// falls once fewer than three entries are free.
// Reset empties the queue and returns the scanner to line 1, offset 0.
module lox_token_scanner import lts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_token_kind,
  output logic [ERR_W-1:0]  out_error_kind,
  output logic [POS_W-1:0]  out_token_start,
  output logic [POS_W-1:0]  out_token_length,
  output logic [LINE_W-1:0] out_line_number,
  output logic              out_run_last
);

  tok_wr_t wr;
  tok_t    head;
  logic    take;
  logic    has_room;

  assign in_ready = has_room;
  assign take     = in_valid & has_room;

  lts_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .text_byte    (in_text_byte),
    .end_of_input (in_end_of_input),
    .wr           (wr)
  );

  lts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd        (out_valid & out_ready),
    .head      (head),
    .not_empty (out_valid),
    .has_room  (has_room)
  );

  assign out_token_kind   = head.kind;
  assign out_error_kind   = head.err;
  assign out_token_start  = head.start;
  assign out_token_length = head.len;
  assign out_line_number  = head.line;
  assign out_run_last     = head.last;

endmodule

// ===== rtl/lts_checker.sv =====
// Port-level checks of the Lox token scanner and their binding to the top level.
module lts_props import lts_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [7:0]        in_text_byte,
  input logic              in_end_of_input,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_token_kind,
  input logic [ERR_W-1:0]  out_error_kind,
  input logic [POS_W-1:0]  out_token_start,
  input logic [POS_W-1:0]  out_token_length,
  input logic [LINE_W-1:0] out_line_number,
  input logic              out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_start) && $stable(out_token_length) && $stable(out_run_last))
    else $error("stalled token changed");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_kind != ERR_NONE |-> out_token_kind == K_ERROR)
    else $error("error code on a token that is not an error");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |-> out_run_last && out_token_length == '0)
    else $error("end-of-input token malformed");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != '0)
    else $error("line number zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token shown after reset");

endmodule

bind lox_token_scanner lts_props u_lts_checker (.*);

// ===== tb/sv/lts_checker.sv =====
// Checker of the Lox token scanner: predicts the tokens of every accepted word and compares.
module lts_checker import lts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_input,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] out_token_kind,
  input  logic [ERR_W-1:0]  out_error_kind,
  input  logic [POS_W-1:0]  out_token_start,
  input  logic [POS_W-1:0]  out_token_length,
  input  logic [LINE_W-1:0] out_line_number,
  input  logic              out_run_last,
  output int                fail_count,
  output int                tokens_owed
);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  mode_t             scan_st;
  op_t               pend_op;
  logic [POS_W-1:0]  byte_pos;
  logic [POS_W-1:0]  lex_at;
  logic [LINE_W-1:0] line_no;
  logic [7:0]        word_buf [KWBUF_DEPTH];
  logic [IDLEN_W-1:0] word_len;

  tok_t step_toks [3];
  int   step_n;
  tok_t awaited_tokens [$];
  int   bad = 0;

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? p : p + 1'b1;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input op_t op, input logic with_eq);
    case (op)
      OP_BANG:    return with_eq ? K_BANG_EQ : K_BANG;
      OP_EQUAL:   return with_eq ? K_EQUAL_EQ : K_EQUAL;
      OP_LESS:    return with_eq ? K_LESS_EQ : K_LESS;
      OP_GREATER: return with_eq ? K_GREATER_EQ : K_GREATER;
      default:    return K_LPAREN;
    endcase
  endfunction

  // The buffered bytes are packed right-aligned, so a match also implies equal length.
  function automatic logic [KIND_W-1:0] word_kind();
    logic [47:0]       w;
    logic [KIND_W-1:0] k;
    w = '0;
    k = K_IDENT;
    for (int j = 0; j < KWBUF_DEPTH; j++)
      if (j < word_len) w = {w[39:0], word_buf[j]};
    if (word_len <= 3'd6) begin
      case (w)
        "and":    k = K_AND;
        "class":  k = K_CLASS;
        "else":   k = K_ELSE;
        "false":  k = K_FALSE;
        "for":    k = K_FOR;
        "fun":    k = K_FUN;
        "if":     k = K_IF;
        "nil":    k = K_NIL;
        "or":     k = K_OR;
        "print":  k = K_PRINT;
        "return": k = K_RETURN;
        "super":  k = K_SUPER;
        "this":   k = K_THIS;
        "true":   k = K_TRUE;
        "var":    k = K_VAR;
        "while":  k = K_WHILE;
        default:  k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  task automatic reset_model();
    scan_st  = M_IDLE;
    pend_op  = OP_NONE;
    byte_pos = '0;
    lex_at   = '0;
    line_no  = LINE_W'(1);
    word_len = '0;
    for (int i = 0; i < KWBUF_DEPTH; i++) word_buf[i] = '0;
  endtask

  task automatic bump_line();
    if (line_no != LINE_MAX) line_no = line_no + 1'b1;
  endtask

  task automatic add_token(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
                           input logic [POS_W-1:0] at, input logic [POS_W-1:0] len);
    if (step_n < 3) begin
      step_toks[step_n].kind  = kind;
      step_toks[step_n].err   = err;
      step_toks[step_n].start = at;
      step_toks[step_n].len   = len;
      step_toks[step_n].line  = line_no;
      step_toks[step_n].last  = 1'b0;
      step_n++;
    end
  endtask

  task automatic split_number(input logic [POS_W-1:0] cur);
    logic [POS_W-1:0] dot;
    dot = (cur > lex_at) ? cur - 1'b1 : lex_at;
    add_token(K_NUMBER, ERR_NONE, lex_at, dot - lex_at);
    add_token(K_DOT, ERR_NONE, dot, POS_W'(1));
  endtask

  task automatic start_lexeme(input logic [7:0] c, input logic [POS_W-1:0] cur);
    logic [POS_W-1:0] one;
    one = next_pos(cur) - cur;
    scan_st = M_IDLE;
    lex_at  = cur;
    case (c)
      " ", CH_CR, CH_TAB: ;
      CH_LF: bump_line();
      "(": add_token(K_LPAREN, ERR_NONE, cur, one);
      ")": add_token(K_RPAREN, ERR_NONE, cur, one);
      "{": add_token(K_LBRACE, ERR_NONE, cur, one);
      "}": add_token(K_RBRACE, ERR_NONE, cur, one);
      ",": add_token(K_COMMA, ERR_NONE, cur, one);
      ".": add_token(K_DOT, ERR_NONE, cur, one);
      "-": add_token(K_MINUS, ERR_NONE, cur, one);
      "+": add_token(K_PLUS, ERR_NONE, cur, one);
      ";": add_token(K_SEMI, ERR_NONE, cur, one);
      "*": add_token(K_STAR, ERR_NONE, cur, one);
      "!": begin scan_st = M_OPER; pend_op = OP_BANG; end
      "=": begin scan_st = M_OPER; pend_op = OP_EQUAL; end
      "<": begin scan_st = M_OPER; pend_op = OP_LESS; end
      ">": begin scan_st = M_OPER; pend_op = OP_GREATER; end
      "/": scan_st = M_SLASH;
      "\"": scan_st = M_STRING;
      default: begin
        if (letter(c)) begin
          scan_st = M_IDENT;
          for (int i = 0; i < KWBUF_DEPTH; i++) word_buf[i] = '0;
          word_buf[0] = c;
          word_len = 3'd1;
        end else if (digit(c)) begin
          scan_st = M_NUMBER;
        end else begin
          add_token(K_ERROR, ERR_UNEXPECTED, cur, one);
        end
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] c, input logic [POS_W-1:0] cur);
    logic [POS_W-1:0] len;
    logic             rescan;
    len    = cur - lex_at;
    rescan = 1'b1;
    case (scan_st)
      M_IDENT: begin
        if (letter(c) || digit(c)) begin
          if (word_len < 6) word_buf[word_len] = c;
          if (word_len < 7) word_len = word_len + 1'b1;
          rescan = 1'b0;
        end else begin
          add_token(word_kind(), ERR_NONE, lex_at, len);
        end
      end
      M_NUMBER: begin
        if (digit(c)) begin
          rescan = 1'b0;
        end else if (c == ".") begin
          scan_st = M_NUMDOT;
          rescan  = 1'b0;
        end else begin
          add_token(K_NUMBER, ERR_NONE, lex_at, len);
        end
      end
      M_NUMDOT: begin
        if (digit(c)) begin
          scan_st = M_FRACTION;
          rescan  = 1'b0;
        end else begin
          split_number(cur);
        end
      end
      M_FRACTION: begin
        if (digit(c)) rescan = 1'b0;
        else add_token(K_NUMBER, ERR_NONE, lex_at, len);
      end
      M_STRING: begin
        rescan = 1'b0;
        if (c == "\"") begin
          add_token(K_STRING, ERR_NONE, lex_at, next_pos(cur) - lex_at);
          scan_st = M_IDLE;
        end else if (c == CH_LF) begin
          bump_line();
        end
      end
      M_OPER: begin
        if (c == "=") begin
          add_token(op_kind(pend_op, 1'b1), ERR_NONE, lex_at, next_pos(cur) - lex_at);
          scan_st = M_IDLE;
          pend_op = OP_NONE;
          rescan  = 1'b0;
        end else begin
          add_token(op_kind(pend_op, 1'b0), ERR_NONE, lex_at, len);
          pend_op = OP_NONE;
        end
      end
      M_SLASH: begin
        if (c == "/") begin
          scan_st = M_COMMENT;
          rescan  = 1'b0;
        end else begin
          add_token(K_SLASH, ERR_NONE, lex_at, len);
        end
      end
      M_COMMENT: if (c != CH_LF) rescan = 1'b0;
      default: ;
    endcase
    if (rescan) start_lexeme(c, cur);
  endtask

  task automatic predict_word(input logic [7:0] c, input logic eoi);
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] len;
    cur    = byte_pos;
    len    = cur - lex_at;
    step_n = 0;
    if (eoi) begin
      case (scan_st)
        M_IDENT:              add_token(word_kind(), ERR_NONE, lex_at, len);
        M_NUMBER, M_FRACTION: add_token(K_NUMBER, ERR_NONE, lex_at, len);
        M_NUMDOT:             split_number(cur);
        M_STRING:             add_token(K_ERROR, ERR_UNTERMINATED, lex_at, len);
        M_OPER:               add_token(op_kind(pend_op, 1'b0), ERR_NONE, lex_at, len);
        M_SLASH:              add_token(K_SLASH, ERR_NONE, lex_at, len);
        default: ;
      endcase
      add_token(K_EOF, ERR_NONE, cur, '0);
      reset_model();
    end else begin
      take_byte(c, cur);
      byte_pos = next_pos(cur);
    end
    if (step_n > 0) step_toks[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) awaited_tokens.push_back(step_toks[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    tok_t want;
    if (!rst_n) begin
      reset_model();
      awaited_tokens.delete();
    end else begin
      if (in_valid && in_ready) predict_word(in_text_byte, in_end_of_input);
      if (out_valid && out_ready) begin
        if (awaited_tokens.size() == 0) begin
          $error("token of kind %0d arrived with nothing expected", out_token_kind);
          bad++;
        end else begin
          want = awaited_tokens.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(out_token_kind));
          check_field("error_kind", 32'(want.err), 32'(out_error_kind));
          check_field("token_start", 32'(want.start), 32'(out_token_start));
          check_field("token_length", 32'(want.len), 32'(out_token_length));
          check_field("line_number", 32'(want.line), 32'(out_line_number));
          check_field("run_last", 32'(want.last), 32'(out_run_last));
        end
      end
    end
    fail_count  <= bad;
    tokens_owed <= awaited_tokens.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top-level testbench of the Lox token scanner: stimulus, idling phases and verdict.
module tb_top import lts_pkg::*; ();

  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 20;
  localparam int TARGET_BYTES = 125;
  localparam int PHASE_BYTES  = 30;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Lexeme forms: 0 to 15 are the keywords, 16 to 34 punctuation and operators.
  localparam int F_FIXED    = 35;
  localparam int F_IDENT    = 35;
  localparam int F_NUMBER   = 36;
  localparam int F_FRACTION = 37;
  localparam int F_NUM_DOT  = 38;
  localparam int F_STRING   = 39;
  localparam int F_COMMENT  = 40;
  localparam int F_NOISE    = 41;
  localparam int F_EOF      = 42;
  localparam int F_SPACE    = 43;
  localparam int NUM_FORMS  = 44;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic [7:0]        in_text_byte    = 8'h00;
  logic              in_end_of_input = 1'b0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  logic [KIND_W-1:0] out_token_kind;
  logic [ERR_W-1:0]  out_error_kind;
  logic [POS_W-1:0]  out_token_start;
  logic [POS_W-1:0]  out_token_length;
  logic [LINE_W-1:0] out_line_number;
  logic              out_run_last;

  int fail_count;
  int tokens_owed;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;
  int bytes_sent     = 0;
  int deck [NUM_FORMS];
  int deck_pos       = NUM_FORMS;

  lox_token_scanner i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_error_kind   (out_error_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_run_last     (out_run_last)
  );

  lts_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_error_kind   (out_error_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_run_last     (out_run_last),
    .fail_count       (fail_count),
    .tokens_owed      (tokens_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic string form_text(input int f);
    case (f)
      0:  return "and";
      1:  return "class";
      2:  return "else";
      3:  return "false";
      4:  return "for";
      5:  return "fun";
      6:  return "if";
      7:  return "nil";
      8:  return "or";
      9:  return "print";
      10: return "return";
      11: return "super";
      12: return "this";
      13: return "true";
      14: return "var";
      15: return "while";
      16: return "(";
      17: return ")";
      18: return "{";
      19: return "}";
      20: return ",";
      21: return ".";
      22: return "-";
      23: return "+";
      24: return ";";
      25: return "/";
      26: return "*";
      27: return "!";
      28: return "!=";
      29: return "=";
      30: return "==";
      31: return ">";
      32: return ">=";
      33: return "<";
      34: return "<=";
      default: return "";
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(3) == 0) return 8'("0" + $urandom_range(9));
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0:       return " ";
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_text_byte    <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_digits();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_word(8'("0" + $urandom_range(9)), 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_owed != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1:       begin src_idle_pct = 50; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 50; end
      default: begin src_idle_pct = 27; sink_stall_pct = 27; end
    endcase
  endtask

  task automatic draw_form(output int f);
    int j;
    int tmp;
    if (deck_pos == NUM_FORMS) begin
      for (int i = 0; i < NUM_FORMS; i++) deck[i] = i;
      for (int i = NUM_FORMS - 1; i > 0; i--) begin
        j       = $urandom_range(i);
        tmp     = deck[i];
        deck[i] = deck[j];
        deck[j] = tmp;
      end
      deck_pos = 0;
    end
    f = deck[deck_pos];
    deck_pos++;
  endtask

  task automatic send_lexeme(input int f);
    logic [7:0] c;
    int         n;
    if (f < F_FIXED) begin
      send_text(form_text(f));
    end else begin
      case (f)
        F_IDENT: begin
          if ($urandom_range(1) == 0) begin
            send_text(form_text($urandom_range(15)));
          end else begin
            send_word(pick_letter(), 1'b0);
          end
          n = $urandom_range(0, 8);
          repeat (n) send_word(pick_alnum(), 1'b0);
        end
        F_NUMBER: send_digits();
        F_FRACTION: begin
          send_digits();
          send_word(".", 1'b0);
          send_digits();
        end
        F_NUM_DOT: begin
          send_digits();
          send_word(".", 1'b0);
          c = 8'($urandom_range(255));
          while (c >= "0" && c <= "9") c = 8'($urandom_range(255));
          send_word(c, 1'b0);
        end
        F_STRING: begin
          send_word("\"", 1'b0);
          n = $urandom_range(0, 6);
          repeat (n) begin
            c = ($urandom_range(4) == 0) ? CH_LF : 8'($urandom_range(255));
            if (c == "\"") c = "'";
            send_word(c, 1'b0);
          end
          if ($urandom_range(99) < 85) send_word("\"", 1'b0);
        end
        F_COMMENT: begin
          send_text("//");
          n = $urandom_range(0, 5);
          repeat (n) begin
            c = 8'($urandom_range(255));
            if (c == CH_LF) c = " ";
            send_word(c, 1'b0);
          end
          send_word(CH_LF, 1'b0);
        end
        F_NOISE: send_word(8'($urandom_range(255)), 1'b0);
        F_EOF:   send_eof();
        default: send_word(pick_space(), 1'b0);
      endcase
    end
    if ($urandom_range(9) < 6) send_word(pick_space(), 1'b0);
  endtask

  initial begin
    int phase;
    int phase_start;
    int f;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_text("1.(");
    send_text("2.5/ ");
    send_text("returns");
    send_text("!");
    send_eof();
    send_word("\"", 1'b0);
    send_text("a");
    send_word(CH_LF, 1'b0);
    send_eof();
    send_text("//");
    send_eof();

    phase       = 0;
    phase_start = bytes_sent;
    set_phase(phase);
    while (bytes_sent < TARGET_BYTES) begin
      draw_form(f);
      send_lexeme(f);
      if (bytes_sent - phase_start >= PHASE_BYTES) begin
        drain();
        phase       = (phase + 1) % 4;
        phase_start = bytes_sent;
        set_phase(phase);
      end
    end

    drain();
    set_phase(0);
    send_text("x");
    send_word(CH_LF, 1'b0);
    send_text("y");
    send_eof();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
